// File: rtl/ops_pkg.sv
`timescale 1ns / 1ps
// ops_pkg: shared sizes, operation codes, microcode word layout and control store for
// the odd-only prime sieve. No dependencies; used by ops_seq and the top level.
package ops_pkg;

  // Largest number the table can hold, and the widths that follow from it
  localparam int MAX_NUMBER = 65535;
  localparam int NUM_W      = 16;                        // fixed field width
  localparam int DEPTH      = MAX_NUMBER + 1;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int I_W        = (ADDR_W + 1) / 2 + 1;      // odd base up to past sqrt
  localparam int SQ_W       = 2 * I_W;
  localparam int J_W        = ADDR_W + 1;                // room to step past limit

  // Transaction operation codes
  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Program step addresses
  localparam step_t S_IDLE     = 4'd0;
  localparam step_t S_DISPATCH = 4'd1;
  localparam step_t S_QREAD    = 4'd2;
  localparam step_t S_QDONE    = 4'd3;
  localparam step_t S_INIT0    = 4'd4;
  localparam step_t S_INIT     = 4'd5;
  localparam step_t S_I3       = 4'd6;
  localparam step_t S_SQ       = 4'd7;
  localparam step_t S_TEST     = 4'd8;
  localparam step_t S_CHK      = 4'd9;
  localparam step_t S_STRIKE   = 4'd10;
  localparam step_t S_NEXT_I   = 4'd11;
  localparam step_t S_BDONE    = 4'd12;

  // Jump conditions: when true, go to target, otherwise fall through
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_IS_BUILD,
    C_J_NE_LIM,
    C_SQ_GT_LIM,
    C_MARK_ZERO,
    C_J_LE_LIM
  } cond_t;

  typedef struct packed {
    logic  latch;       // capture a transaction when start is high
    logic  rd_idx;      // read mark at query index
    logic  rd_i;        // read mark at odd base i
    logic  emit_query;  // post query result
    logic  emit_build;  // post build result, commit limit
    logic  clr_j;       // j = 0
    logic  wr_init;     // write candidate pattern at j
    logic  inc_j;       // j += 1
    logic  set_i;       // i = 3
    logic  load_sq;     // sq = i * i
    logic  load_j_sq;   // j = sq
    logic  wr_zero;     // strike j while j <= limit
    logic  step_j;      // j += 2i
    logic  inc_i;       // i += 2
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic start;
    logic is_build;
    logic j_ne_lim;
    logic sq_gt_lim;
    logic mark_zero;
    logic j_le_lim;
  } status_t;

  // Control store
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '0;
    w.cond = C_NEVER;
    w.target = S_IDLE;
    unique case (s)
      S_IDLE: begin
        w.latch = 1'b1; w.cond = C_NO_START; w.target = S_IDLE;
      end
      S_DISPATCH: begin
        w.cond = C_IS_BUILD; w.target = S_INIT0;
      end
      S_QREAD: begin
        w.rd_idx = 1'b1;
      end
      S_QDONE: begin
        w.emit_query = 1'b1; w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_INIT0: begin
        w.clr_j = 1'b1;
      end
      S_INIT: begin
        w.wr_init = 1'b1; w.inc_j = 1'b1; w.cond = C_J_NE_LIM; w.target = S_INIT;
      end
      S_I3: begin
        w.set_i = 1'b1;
      end
      S_SQ: begin
        w.load_sq = 1'b1; w.rd_i = 1'b1;
      end
      S_TEST: begin
        w.cond = C_SQ_GT_LIM; w.target = S_BDONE;
      end
      S_CHK: begin
        w.load_j_sq = 1'b1; w.cond = C_MARK_ZERO; w.target = S_NEXT_I;
      end
      S_STRIKE: begin
        w.wr_zero = 1'b1; w.step_j = 1'b1; w.cond = C_J_LE_LIM; w.target = S_STRIKE;
      end
      S_NEXT_I: begin
        w.inc_i = 1'b1; w.cond = C_ALWAYS; w.target = S_SQ;
      end
      S_BDONE: begin
        w.emit_build = 1'b1; w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/ops_ram.sv
`timescale 1ns / 1ps
// ops_ram: generic one-write, one-read RAM with registered read data.
// No dependencies.
module ops_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/ops_seq.sv
`timescale 1ns / 1ps
// ops_seq: step counter and control store lookup for the prime sieve.
// Depends on ops_pkg.
module ops_seq (
  input  logic             clk,
  input  logic             rst,
  input  ops_pkg::status_t status,
  output ops_pkg::uword_t  ctrl,
  output logic             busy
);
  import ops_pkg::*;

  step_t  pc;
  step_t  pc_next;
  uword_t w;
  logic   take;

  assign w    = ucode(pc);
  assign ctrl = w;
  assign busy = (pc != S_IDLE);

  // Evaluate the jump condition of the current step
  always_comb begin
    unique case (w.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_START:  take = !status.start;
      C_IS_BUILD:  take = status.is_build;
      C_J_NE_LIM:  take = status.j_ne_lim;
      C_SQ_GT_LIM: take = status.sq_gt_lim;
      C_MARK_ZERO: take = status.mark_zero;
      C_J_LE_LIM:  take = status.j_le_lim;
      default:     take = 1'b1;
    endcase
    pc_next = take ? w.target : pc + step_t'(1);
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: rtl/odd_only_prime_sieve_top.sv
`timescale 1ns / 1ps
// odd_only_prime_sieve_top: datapath and mark memory of the odd-only prime sieve.
// Depends on ops_pkg, ops_seq and ops_ram.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low;
//   op, limit and index are sampled then. op = 0 builds the mark table for
//   0..limit, op = 1 queries the mark at index. Every transaction gives one
//   result: done is high for exactly one cycle with is_prime and
//   out_of_range. The receiver cannot stall; results must be taken as shown.
// Sequence:
//   A query steps through S_DISPATCH, S_QREAD and S_QDONE after the accepting
//   edge, with busy high in each; done is registered from S_QDONE, and a new
//   transaction can be taken once the sequencer is back in S_IDLE.
//   A build writes one entry per cycle in S_INIT and S_STRIKE through the single
//   write port of the mark memory: S_INIT0 and S_INIT fill entries 0..limit, then
//   S_SQ, S_TEST, S_CHK and S_NEXT_I run for each odd base i with i*i <= limit,
//   with S_STRIKE clearing the odd multiples of each base still marked; a final S_SQ
//   and S_TEST end the loop before S_BDONE; busy stays high for the whole build.
// Reset:
//   Synchronous rst returns the sequencer to idle, drops done and marks the
//   table as unbuilt; queries then report out_of_range until a build.
module odd_only_prime_sieve_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     op,
  input  logic [ops_pkg::NUM_W-1:0] limit,
  input  logic [ops_pkg::NUM_W-1:0] index,
  output logic                     done,
  output logic                     is_prime,
  output logic                     out_of_range
);
  import ops_pkg::*;

  uword_t  ctrl;
  status_t status;

  logic              op_reg;
  logic [ADDR_W-1:0] lim_reg;
  logic [NUM_W-1:0]  idx_reg;
  logic [I_W-1:0]    i_reg;
  logic [SQ_W-1:0]   sq_reg;
  logic [J_W-1:0]    j_reg;
  logic [ADDR_W-1:0] built_limit;
  logic              table_valid;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_data;
  logic              init_bit;
  logic              j_le_lim;
  logic              idx_oor;
  logic [ADDR_W-1:0] lim_sat;

  ops_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  ops_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_marks (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Status for the sequencer jumps
  assign j_le_lim = (j_reg <= J_W'(lim_reg));
  always_comb begin
    status.start     = start;
    status.is_build  = (op_reg == OP_BUILD);
    status.j_ne_lim  = (j_reg != J_W'(lim_reg));
    status.sq_gt_lim = (sq_reg > SQ_W'(lim_reg));
    status.mark_zero = !rd_data;
    status.j_le_lim  = j_le_lim;
  end

  // Candidate pattern: 2 and every odd number from 3
  assign init_bit = (j_reg == J_W'(2)) || (j_reg[0] && (j_reg != J_W'(1)));

  // Memory ports
  assign wr_en   = ctrl.wr_init || (ctrl.wr_zero && j_le_lim);
  assign wr_addr = j_reg[ADDR_W-1:0];
  assign wr_data = ctrl.wr_init ? init_bit : 1'b0;
  assign rd_en   = ctrl.rd_idx || ctrl.rd_i;
  assign rd_addr = ctrl.rd_idx ? ADDR_W'(idx_reg) : ADDR_W'(i_reg);

  // Clamp the build limit to the table size
  assign lim_sat = (32'(limit) > MAX_NUMBER) ? ADDR_W'(MAX_NUMBER) : ADDR_W'(limit);

  // Query range check
  assign idx_oor = !table_valid || (32'(idx_reg) > 32'(built_limit)) ||
                   (32'(idx_reg) > MAX_NUMBER);

  // Datapath registers and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      built_limit <= '0;
      table_valid <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= ctrl.emit_query || ctrl.emit_build;
      if (ctrl.emit_build) begin
        built_limit <= lim_reg;
        table_valid <= 1'b1;
      end
    end
    // hold the transaction fields
    if (ctrl.latch && start) begin
      op_reg  <= op;
      lim_reg <= lim_sat;
      idx_reg <= index;
    end
    if (ctrl.emit_query) begin
      is_prime     <= !idx_oor && rd_data;
      out_of_range <= idx_oor;
    end else if (ctrl.emit_build) begin
      is_prime     <= 1'b0;
      out_of_range <= 1'b0;
    end
    // advance the sieve indices
    if (ctrl.clr_j) begin
      j_reg <= '0;
    end else if (ctrl.inc_j) begin
      j_reg <= j_reg + J_W'(1);
    end else if (ctrl.load_j_sq) begin
      j_reg <= J_W'(sq_reg);
    end else if (ctrl.step_j) begin
      j_reg <= j_reg + J_W'({i_reg, 1'b0});
    end
    if (ctrl.set_i) begin
      i_reg <= I_W'(3);
    end else if (ctrl.inc_i) begin
      i_reg <= i_reg + I_W'(2);
    end
    if (ctrl.load_sq) begin
      sq_reg <= SQ_W'(i_reg) * SQ_W'(i_reg);
    end
  end

  // Checks
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_oor_not_prime: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_range) |-> !is_prime)
    else $error("out-of-range result flagged prime");

  a_write_in_span: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (J_W'(wr_addr) <= J_W'(lim_reg)))
    else $error("mark write beyond build limit");

endmodule

// File: test/odd_only_prime_sieve_top_tb.sv
`timescale 1ns / 1ps
// odd_only_prime_sieve_top_tb: self-checking bench for the odd-only prime sieve.
// Depends on ops_pkg and odd_only_prime_sieve_top; runs builds and queries against a local sieve.
module odd_only_prime_sieve_top_tb;
  import ops_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct {
    logic                      op;
    logic [ops_pkg::NUM_W-1:0] limit;
    logic [ops_pkg::NUM_W-1:0] index;
    int unsigned               idle_pct;
  } sieve_cmd_t;

  typedef struct {
    logic is_prime;
    logic out_of_range;
  } sieve_answer_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      op = OP_BUILD;
  logic [ops_pkg::NUM_W-1:0] limit = '0;
  logic [ops_pkg::NUM_W-1:0] index = '0;
  logic                      busy;
  logic                      done;
  logic                      is_prime;
  logic                      out_of_range;

  // Pending commands, and answers owed by the block in issue order
  sieve_cmd_t    cmd_q[$];
  sieve_answer_t answer_q[$];
  sieve_cmd_t    next_cmd;
  sieve_answer_t want;

  // Local copy of the mark table and build state
  bit                        sieve_marks [0:ops_pkg::MAX_NUMBER];
  logic [ops_pkg::NUM_W-1:0] table_limit = '0;
  bit                        table_built = 1'b0;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned n_builds = 0;
  int unsigned n_queries = 0;
  int unsigned n_primes = 0;
  int unsigned n_oob = 0;
  int unsigned gen_limit = 0;
  bit          gen_built = 1'b0;

  odd_only_prime_sieve_top u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .limit        (limit),
    .index        (index),
    .done         (done),
    .is_prime     (is_prime),
    .out_of_range (out_of_range)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Rebuild the table: candidates are 2 and every odd from 3, then strike odd multiples
  function automatic void sieve_rebuild(int unsigned lim);
    for (int unsigned k = 0; k <= lim; k++) begin
      sieve_marks[k] = (k == 2) || (k >= 3 && (k % 2) == 1);
    end
    for (int unsigned b = 3; b * b <= lim; b += 2) begin
      if (sieve_marks[b]) begin
        for (int unsigned m = b * b; m <= lim; m += 2 * b) begin
          sieve_marks[m] = 1'b0;
        end
      end
    end
  endfunction

  // Work out the answer for one accepted transaction and queue it
  function automatic void predict_answer(logic cmd_op, logic [ops_pkg::NUM_W-1:0] cmd_limit,
                                         logic [ops_pkg::NUM_W-1:0] cmd_index);
    sieve_answer_t ans;
    int unsigned   lim;
    ans.is_prime     = 1'b0;
    ans.out_of_range = 1'b0;
    if (cmd_op == OP_BUILD) begin
      lim = cmd_limit;
      if (lim > ops_pkg::MAX_NUMBER) lim = ops_pkg::MAX_NUMBER;
      sieve_rebuild(lim);
      table_limit = lim[ops_pkg::NUM_W-1:0];
      table_built = 1'b1;
      n_builds++;
    end else begin
      n_queries++;
      if (!table_built || cmd_index > table_limit || cmd_index > ops_pkg::MAX_NUMBER) begin
        ans.out_of_range = 1'b1;
        n_oob++;
      end else begin
        ans.is_prime = sieve_marks[cmd_index];
        if (ans.is_prime) n_primes++;
      end
    end
    answer_q.push_back(ans);
  endfunction

  function automatic void add_cmd(logic cmd_op, int unsigned cmd_limit, int unsigned cmd_index,
                                  int unsigned idle);
    sieve_cmd_t c;
    c.op       = cmd_op;
    c.limit    = cmd_limit[ops_pkg::NUM_W-1:0];
    c.index    = cmd_index[ops_pkg::NUM_W-1:0];
    c.idle_pct = idle;
    cmd_q.push_back(c);
  endfunction

  // Driver: record the transaction taken at this edge, then present the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_answer(op, limit, index);
      end
      if (!start || !busy) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= cmd_q[0].idle_pct) begin
          next_cmd = cmd_q.pop_front();
          start <= 1'b1;
          op    <= next_cmd.op;
          limit <= next_cmd.limit;
          index <= next_cmd.index;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest owed answer
  always @(posedge clk) begin
    if (!rst && done) begin
      if (answer_q.size() == 0) begin
        $display("%0t: result with nothing owed: is_prime=%b out_of_range=%b",
                 $time, is_prime, out_of_range);
        error_count++;
      end else begin
        want = answer_q.pop_front();
        if (is_prime !== want.is_prime) begin
          $display("%0t: is_prime expected %b got %b", $time, want.is_prime, is_prime);
          error_count++;
        end
        if (out_of_range !== want.out_of_range) begin
          $display("%0t: out_of_range expected %b got %b",
                   $time, want.out_of_range, out_of_range);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d answers owed", $time, answer_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned idle_by_phase [4];
    int unsigned phase_len;
    int unsigned idle;
    int unsigned pick;
    int unsigned lim;
    int unsigned idx;

    // Directed: queries before any build, tiny tables, exact square limit, full range
    add_cmd(OP_QUERY, 0, 0, 0);
    add_cmd(OP_QUERY, 0, 65535, 0);
    add_cmd(OP_BUILD, 0, 0, 0);
    add_cmd(OP_QUERY, 0, 0, 0);
    add_cmd(OP_QUERY, 0, 1, 0);
    add_cmd(OP_BUILD, 1, 0, 0);
    add_cmd(OP_QUERY, 0, 1, 0);
    add_cmd(OP_BUILD, 2, 0, 0);
    add_cmd(OP_QUERY, 0, 2, 0);
    add_cmd(OP_BUILD, 9, 0, 0);
    add_cmd(OP_QUERY, 0, 9, 0);
    add_cmd(OP_QUERY, 0, 7, 0);
    add_cmd(OP_QUERY, 0, 10, 0);
    add_cmd(OP_BUILD, 25, 65535, 0);
    add_cmd(OP_QUERY, 0, 25, 0);
    add_cmd(OP_QUERY, 65535, 23, 0);
    add_cmd(OP_BUILD, 65535, 0, 0);
    add_cmd(OP_QUERY, 0, 65535, 0);
    add_cmd(OP_QUERY, 0, 65521, 0);
    add_cmd(OP_QUERY, 0, 0, 0);
    add_cmd(OP_QUERY, 0, 2, 0);
    add_cmd(OP_QUERY, 0, 3, 0);
    add_cmd(OP_QUERY, 0, 4, 0);
    add_cmd(OP_QUERY, 0, 32768, 0);
    gen_limit = 65535;
    gen_built = 1'b1;

    // Random phases: no gaps, heavy sender gaps, no gaps (receiver cannot stall), light gaps
    idle_by_phase[0] = 0;
    idle_by_phase[1] = 64;
    idle_by_phase[2] = 0;
    idle_by_phase[3] = 25;
    phase_len = RANDOM_ITEMS / 4;
    for (int p = 0; p < 4; p++) begin
      idle = idle_by_phase[p];
      for (int unsigned n = 0; n < phase_len; n++) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          // Keep most tables small so builds stay short
          if ($urandom_range(99) < 85) lim = $urandom_range(300, 0);
          else lim = $urandom_range(2047, 301);
          add_cmd(OP_BUILD, lim, $urandom_range(65535), idle);
          gen_limit = lim;
          gen_built = 1'b1;
        end else begin
          pick = $urandom_range(99);
          if (pick < 70 && gen_built) begin
            idx = $urandom_range(gen_limit, 0);
          end else if (pick < 80) begin
            idx = gen_limit + $urandom_range(1);
            if (idx > 65535) idx = 65535;
          end else begin
            idx = $urandom_range(65535);
          end
          add_cmd(OP_QUERY, $urandom_range(65535), idx, idle);
        end
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Drain: every transaction taken, every answer back, then a short settle
    while (cmd_q.size() != 0 || start) @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d builds and %0d queries: %0d prime answers, %0d out-of-range answers",
             n_builds, n_queries, n_primes, n_oob);
    if (error_count == 0 && answer_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
